// ----- sv/far_pkg.sv -----
// Package for the fractional audio resampler.
// Holds shared widths, register indexes, the controller state and command/status types.
// Depends on nothing.
`default_nettype none

package far_pkg;

	localparam int PHASE_BITS_DEF  = 12;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;
	localparam int MODE_W     = 2;
	localparam int INC_W      = 18;
	localparam int START_W    = 12;
	localparam int SKIP_W     = 6;
	localparam int STEP_W     = 2;

	localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;
	localparam logic [INC_W-1:0]  INC_RESET  = 18'd4096;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE  = 2'd0,
		REG_INC   = 2'd1,
		REG_START = 2'd2
	} cfg_reg_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_NEAREST = 2'd0,
		MODE_LINEAR  = 2'd1,
		MODE_CUBIC   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		AD_B,
		AD_K2,
		AD_K1,
		AD_K0
	} addend_t;

	typedef struct packed {
		logic    shift;
		logic    skip_dec;
		logic    load;
		logic    mac;
		addend_t addend;
		logic    emit;
	} dp_cmd_t;

	typedef struct packed {
		logic              skip_nz;
		logic              adv_nz;
		logic [MODE_W-1:0] mode;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- sv/far_ctrl.sv -----
// Controller for the fractional audio resampler.
// Sequences accept, coefficient load, multiply-add steps and result emit.
// Depends on far_pkg.
`default_nettype none

module far_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	input  far_pkg::dp_status_t   status,
	output far_pkg::dp_cmd_t      cmd
);
	import far_pkg::*;

	state_t              state_q, state_nxt;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	logic                accept;
	logic                out_free;
	logic                is_linear;
	logic                last_step;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign is_linear = (status.mode == MODE_LINEAR);
	assign last_step = is_linear ? (step_q == STEP_W'(0)) : (step_q == STEP_W'(2));
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !status.skip_nz)
					state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (status.mode == MODE_NEAREST)
					state_nxt = ST_EMIT;
				else
					state_nxt = ST_MAC;
			end
			ST_MAC: begin
				if (last_step)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free)
					state_nxt = status.adv_nz ? ST_IDLE : ST_LOAD;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		cmd          = '0;
		cmd.addend   = AD_B;
		case (state_q)
			ST_IDLE: begin
				in_stall     = 1'b0;
				cmd.shift    = accept;
				cmd.skip_dec = accept && status.skip_nz;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
				if (is_linear)
					cmd.addend = AD_B;
				else begin
					case (step_q)
						2'd0:    cmd.addend = AD_K2;
						2'd1:    cmd.addend = AD_K1;
						default: cmd.addend = AD_K0;
					endcase
				end
			end
			ST_EMIT: begin
				cmd.emit = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MAC)
				step_q <= step_q + STEP_W'(1);
			else
				step_q <= '0;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ----- sv/far_dp.sv -----
// Datapath for the fractional audio resampler.
// Config registers, sample history, phase accumulator, shared multiply-add and output register.
// Depends on far_pkg.
`default_nettype none

module far_dp #(
	parameter int PHASE_BITS  = far_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = far_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [far_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [far_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire  signed [SAMPLE_BITS-1:0]       in_sample,
	input  far_pkg::dp_cmd_t                    cmd,
	output far_pkg::dp_status_t                 status,
	output logic signed [SAMPLE_BITS-1:0]       out_sample,
	output logic                                last_of_run
);
	import far_pkg::*;

	localparam int AW  = SAMPLE_BITS + 5;
	localparam int TW  = PHASE_BITS + 1;
	localparam int PW  = AW + TW;
	localparam int IW  = PHASE_BITS + 6;
	localparam int ACW = PHASE_BITS + 7;
	localparam int CW  = (INC_W > ACW) ? INC_W : ACW;
	localparam logic [CW-1:0] INC_MIN = CW'(1) << (PHASE_BITS - 6);
	localparam logic [CW-1:0] INC_MAX = (CW'(64) << PHASE_BITS) - CW'(1);
	localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic [MODE_W-1:0]             mode_q;
	logic [INC_W-1:0]              inc_q;
	logic [PHASE_BITS-1:0]         phase_q;
	logic [SKIP_W-1:0]             skip_q;
	logic signed [SAMPLE_BITS-1:0] hist_q [4];
	logic signed [AW-1:0]          acc_q;

	logic [CW-1:0]                 inc_ext, inc_cl;
	logic [ACW-1:0]                acc_sum;
	logic [ACW-PHASE_BITS-1:0]     adv;
	logic signed [AW-1:0]          ha, hb, hc, hd;
	logic signed [AW-1:0]          k3, k2, k1, k0, cmb, bc;
	logic signed [AW-1:0]          load_val, addend, mac_val, res_v;
	logic signed [TW-1:0]          t_s;
	logic signed [PW-1:0]          prod;
	logic signed [SAMPLE_BITS-1:0] sat_v;
	logic                          in_range;

	// phase step, clamped so one input that is not skipped yields 1..64 results
	assign inc_ext = CW'(inc_q);
	always_comb begin
		if (inc_ext < INC_MIN)
			inc_cl = INC_MIN;
		else if (inc_ext > INC_MAX)
			inc_cl = INC_MAX;
		else
			inc_cl = inc_ext;
	end
	assign acc_sum = ACW'(phase_q) + ACW'(inc_cl[IW-1:0]);
	assign adv     = acc_sum[ACW-1:PHASE_BITS];

	assign ha = {{5{hist_q[0][SAMPLE_BITS-1]}}, hist_q[0]};
	assign hb = {{5{hist_q[1][SAMPLE_BITS-1]}}, hist_q[1]};
	assign hc = {{5{hist_q[2][SAMPLE_BITS-1]}}, hist_q[2]};
	assign hd = {{5{hist_q[3][SAMPLE_BITS-1]}}, hist_q[3]};

	assign bc  = hb - hc;
	assign k3  = hd - ha + (bc <<< 1) + bc;
	assign k2  = (ha <<< 1) - (hb <<< 2) - hb + (hc <<< 2) - hd;
	assign k1  = hc - ha;
	assign k0  = hb <<< 1;
	assign cmb = hc - hb;

	always_comb begin
		case (mode_q)
			MODE_NEAREST: load_val = hb;
			MODE_LINEAR:  load_val = cmb;
			default:      load_val = k3;
		endcase
	end

	always_comb begin
		case (cmd.addend)
			AD_B:    addend = hb;
			AD_K2:   addend = k2;
			AD_K1:   addend = k1;
			AD_K0:   addend = k0;
			default: addend = hb;
		endcase
	end

	// floor((acc * t) >> PHASE_BITS) + addend
	assign t_s     = {1'b0, phase_q};
	assign prod    = acc_q * t_s;
	assign mac_val = prod[PHASE_BITS+AW-1:PHASE_BITS] + addend;

	always_comb begin
		case (mode_q)
			MODE_NEAREST, MODE_LINEAR: res_v = acc_q;
			default:                   res_v = acc_q >>> 1;
		endcase
	end

	assign in_range = (&res_v[AW-1:SAMPLE_BITS-1]) || !(|res_v[AW-1:SAMPLE_BITS-1]);
	assign sat_v    = in_range ? res_v[SAMPLE_BITS-1:0] : (res_v[AW-1] ? SMIN : SMAX);

	assign status.skip_nz = |skip_q;
	assign status.adv_nz  = |adv;
	assign status.mode    = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RESET;
			inc_q   <= INC_RESET;
			phase_q <= '0;
			skip_q  <= '0;
			for (int i = 0; i < 4; i++)
				hist_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:  mode_q <= cfg_data[MODE_W-1:0];
					REG_INC:   inc_q  <= cfg_data[INC_W-1:0];
					REG_START: begin
						phase_q <= PHASE_BITS'(cfg_data[START_W-1:0]);
						skip_q  <= '0;
					end
					default: ;
				endcase
			end else begin
				if (cmd.skip_dec)
					skip_q <= skip_q - SKIP_W'(1);
				else if (cmd.emit && status.adv_nz)
					skip_q <= adv[SKIP_W-1:0] - SKIP_W'(1);
				if (cmd.emit)
					phase_q <= acc_sum[PHASE_BITS-1:0];
			end
			if (cmd.shift) begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= hist_q[3];
				hist_q[3] <= in_sample;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			acc_q <= load_val;
		else if (cmd.mac)
			acc_q <= mac_val;
		if (cmd.emit) begin
			out_sample  <= sat_v;
			last_of_run <= status.adv_nz;
		end
	end

endmodule

`default_nettype wire

// ----- sv/fractional_audio_resampler_core.sv -----
// Channel   Handshake            Payload
// in        in_valid / in_stall  in_sample
// out       out_valid / out_stall out_sample, last_of_run
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A source sample is accepted in idle; a skipped sample only shifts the history and the controller stays idle.
// Each result then runs load, the multiply-add steps (none for nearest) and emit, on the single
// shared multiply-add that walks the Horner chain one term per cycle.
// The result register decouples the output: emit waits only while it is full and stalled.
// Reset is asynchronous and restores the register defaults, zero history and zero phase.
//
// Top level of the fractional audio resampler; depends on far_pkg, far_ctrl, far_dp.
`default_nettype none

module fractional_audio_resampler_core #(
	parameter int PHASE_BITS  = far_pkg::PHASE_BITS_DEF,
	parameter int SAMPLE_BITS = far_pkg::SAMPLE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  signed [SAMPLE_BITS-1:0]    in_sample,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic signed [SAMPLE_BITS-1:0]    out_sample,
	output logic                             last_of_run,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [far_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire  [far_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import far_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	far_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	far_dp #(
		.PHASE_BITS  (PHASE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_sample   (in_sample),
		.cmd         (cmd),
		.status      (status),
		.out_sample  (out_sample),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

// ----- sv/far_checker.sv -----
// Port-level checks for the fractional audio resampler, bound to the top level.
// Depends on fractional_audio_resampler_core.
`default_nettype none

module far_checker #(
	parameter int SAMPLE_BITS = far_pkg::SAMPLE_BITS_DEF
) (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   in_valid,
	input wire                   in_stall,
	input wire                   out_valid,
	input wire                   out_stall,
	input wire [SAMPLE_BITS-1:0] out_sample,
	input wire                   last_of_run,
	input wire                   cfg_ready
);

	// held result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_sample) && $stable(last_of_run))
		else $error("out payload changed while stalled");

	// a new result only appears when input was blocked in the previous cycle
	a_rise_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input was open");

	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result right after input beat");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port not ready");

endmodule

bind fractional_audio_resampler_core far_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_far_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_sample  (out_sample),
	.last_of_run (last_of_run),
	.cfg_ready   (cfg_ready)
);

`default_nettype wire

// ----- bench/fractional_audio_resampler_core_tb.sv -----
// Self-checking bench for fractional_audio_resampler_core: random and directed samples under
// every mode and many rates, with a built-in resampler predictor checked beat by beat on the output.
// Depends on far_pkg and the core RTL.
`default_nettype none

module fractional_audio_resampler_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import far_pkg::*;

	localparam int PB = PHASE_BITS_DEF;
	localparam int MAX_RUN = 64;
	localparam int INC_MIN = 1 << (PB - 6);
	localparam int INC_MAX = (64 << PB) - 1;
	localparam int TAIL = 16;
	localparam longint LIMIT = 64'd500 * MAX_RUN * 66 * 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic signed [SAMPLE_BITS_DEF-1:0] smp;
		logic                              last;
	} out_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] in_sample = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] out_sample;
	logic last_of_run;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// predictor state
	logic signed [15:0] hist [4];
	logic [11:0] phase_acc;
	logic [5:0] skip_cnt;
	logic [1:0] mode_reg;
	logic [17:0] inc_reg;
	logic [11:0] start_reg;

	logic signed [15:0] sample_q [$];
	out_beat_t out_q [$];
	int errors = 0;
	longint cycles = 0;
	bit steady = 1'b0;
	int gap_left = 0;
	int stall_left = 0;

	fractional_audio_resampler_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_sample(out_sample), .last_of_run(last_of_run),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [15:0] rand_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh7FFF;
		if (r == 1) return 16'sh8000;
		return 16'($urandom());
	endfunction

	function automatic logic signed [15:0] interp_point(logic [11:0] t);
		longint a, b, c, d, tt, r;
		a = longint'(hist[0]);
		b = longint'(hist[1]);
		c = longint'(hist[2]);
		d = longint'(hist[3]);
		tt = longint'(t);
		case (mode_reg)
			MODE_NEAREST: r = b;
			MODE_LINEAR: r = b + (((c - b) * tt) >>> PB);
			default: begin
				r = -a + 3 * b - 3 * c + d;
				r = ((r * tt) >>> PB) + (2 * a - 5 * b + 4 * c - d);
				r = ((r * tt) >>> PB) + (c - a);
				r = ((r * tt) >>> PB) + 2 * b;
				r = r >>> 1;
			end
		endcase
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	task automatic resample_step(logic signed [15:0] s);
		logic [31:0] eff, acc, adv;
		out_beat_t beat;
		int n;
		bit done;
		eff = 32'(inc_reg);
		if (eff < INC_MIN) eff = INC_MIN;
		if (eff > INC_MAX) eff = INC_MAX;
		hist[0] = hist[1];
		hist[1] = hist[2];
		hist[2] = hist[3];
		hist[3] = s;
		if (skip_cnt != 0) begin
			skip_cnt--;
			return;
		end
		n = 0;
		done = 1'b0;
		while (!done) begin
			beat.smp = interp_point(phase_acc);
			acc = phase_acc + eff;
			adv = acc >> PB;
			phase_acc = acc[11:0];
			n++;
			if (adv != 0) skip_cnt = 6'(adv - 1);
			done = (adv != 0) || (n == MAX_RUN);
			beat.last = done;
			out_q.push_back(beat);
		end
	endtask

	task automatic apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_MODE: mode_reg = data[1:0];
			REG_INC: inc_reg = data;
			REG_START: begin
				start_reg = data[11:0];
				phase_acc = start_reg;
				skip_cnt = '0;
			end
			default: ;
		endcase
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_cfg(idx, data);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (sample_q.size() != 0 || in_valid || out_q.size() != 0) @(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic feed_random(int n);
		for (int i = 0; i < n; i++) sample_q.push_back(rand_sample());
		wait_quiet();
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) resample_step(in_sample);
			if (in_valid && in_stall) begin
			end else if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (sample_q.size() != 0) begin
				in_sample <= sample_q.pop_front();
				in_valid <= 1'b1;
				gap_left = idle_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_beat;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (out_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected beat, expected none, actual %0d last %0b",
						$realtime, out_sample, last_of_run);
				end else begin
					exp_beat = out_q.pop_front();
					if (out_sample !== exp_beat.smp) begin
						errors++;
						$display("%0t: out_sample expected %0d actual %0d",
							$realtime, exp_beat.smp, out_sample);
					end
					if (last_of_run !== exp_beat.last) begin
						errors++;
						$display("%0t: last_of_run expected %0b actual %0b",
							$realtime, exp_beat.last, last_of_run);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = idle_len();
				out_stall <= (stall_left > 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	initial begin
		int kind;
		int cnt;
		mode_reg = MODE_RESET;
		inc_reg = INC_RESET;
		start_reg = '0;
		phase_acc = '0;
		skip_cnt = '0;
		for (int i = 0; i < 4; i++) hist[i] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset defaults: linear at unity rate, full-scale swings
		sample_q.push_back(16'sh7FFF);
		sample_q.push_back(16'sh8000);
		sample_q.push_back(16'sh7FFF);
		sample_q.push_back(16'sh8000);
		wait_quiet();

		// cubic at half rate, overshoot must saturate
		cfg_write(REG_MODE, CFG_DATA_W'(MODE_CUBIC));
		cfg_write(REG_INC, 18'd2048);
		cfg_write(REG_START, 18'd3000);
		sample_q.push_back(16'sh7FFF);
		sample_q.push_back(16'sh8000);
		sample_q.push_back(16'sh7FFF);
		sample_q.push_back(16'sh8000);
		sample_q.push_back(16'sh0000);
		sample_q.push_back(16'shFFFF);
		wait_quiet();

		// spare mode with masked upper bits, increment below minimum: full runs
		cfg_write(REG_MODE, 18'h3FFFF);
		cfg_write(REG_INC, 18'd0);
		cfg_write(REG_START, 18'd0);
		sample_q.push_back(16'sh8000);
		sample_q.push_back(16'sh7FFF);
		wait_quiet();

		// nearest, largest step: skipped inputs, then start phase clears the skip
		cfg_write(REG_MODE, 18'h20000 | MODE_NEAREST);
		cfg_write(REG_INC, 18'h3FFFF);
		cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 18'h3FFFF)));
		cfg_write(REG_START, 18'd4095);
		sample_q.push_back(16'sh1234);
		sample_q.push_back(16'sh8000);
		sample_q.push_back(16'sh7FFF);
		wait_quiet();
		cfg_write(REG_START, 18'h3F000);
		sample_q.push_back(16'shFFFF);
		wait_quiet();

		cfg_write(REG_MODE, CFG_DATA_W'(MODE_LINEAR));
		cfg_write(REG_INC, 18'd5000);
		cfg_write(REG_START, 18'd4095);
		for (int i = 0; i < 6; i++) sample_q.push_back(rand_sample());
		wait_quiet();

		for (int p = 0; p < 9; p++) begin
			steady = (p % 3 == 1);
			kind = $urandom_range(0, 9);
			cfg_write(REG_MODE, CFG_DATA_W'($urandom_range(0, 18'h3FFFF)));
			if (kind == 0) begin
				cfg_write(REG_INC, CFG_DATA_W'($urandom_range(0, 200)));
				cnt = 10;
			end else if (kind == 1) begin
				cfg_write(REG_INC, CFG_DATA_W'($urandom_range(32768, 18'h3FFFF)));
				cnt = 48;
			end else begin
				cfg_write(REG_INC, CFG_DATA_W'($urandom_range(1024, 16384)));
				cnt = 48;
			end
			cfg_write(REG_START, CFG_DATA_W'($urandom_range(0, 18'h3FFFF)));
			feed_random(cnt / 2);
			feed_random(cnt - cnt / 2);
		end
		steady = 1'b0;
		wait_quiet();

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
